// ===== hdl/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants of the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [4:0] HDR_LEN      = 5'd12;
  localparam logic [4:0] CHUNK_HDR_LEN = 5'd8;
  localparam logic [4:0] TAG_LEN      = 5'd4;
  localparam logic [4:0] FMT_BODY_LEN = 5'd16;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] SAMPLE_BITS = 16'd16;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_BAD_RIFF  = 3'd2;
  localparam logic [2:0] ST_BAD_WAVE  = 3'd3;
  localparam logic [2:0] ST_NOT_PCM   = 3'd4;
  localparam logic [2:0] ST_NOT_16BIT = 3'd5;
  localparam logic [2:0] ST_NO_FMT    = 3'd6;
  localparam logic [2:0] ST_NO_DATA   = 3'd7;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_FHDR,
    PH_FBODY,
    PH_FSKIP,
    PH_DHDR,
    PH_DSKIP,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_align;
    logic [31:0] payload_size;
  } result_t;

endpackage

// ===== hdl/wrp_fifo.sv =====
// ----------------------------------------------------------------------------
// wrp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wrp_fifo #(
  parameter int Depth = 2,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/wrp_parser.sv =====
// ----------------------------------------------------------------------------
// wrp_parser
// Byte-wise RIFF/WAVE chunk walker; emits at most one result per stream.
// ----------------------------------------------------------------------------
module wrp_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  wrp_pkg::beat_t  in_beat_i,
  output logic            in_pop_o,
  input  logic            res_ready_i,
  output logic            res_valid_o,
  output wrp_pkg::result_t res_o
);
  import wrp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [4:0]      idx_q, idx_d;
  logic [31:0]     word_q, word_d;
  logic [31:0]     tag_q, tag_d;
  logic [32:0]     skip_q, skip_d;
  logic [15:0][7:0] fmt_q, fmt_d;

  logic        fire;
  logic [7:0]  b;
  logic [31:0] ws_sh;
  logic [4:0]  idx_inc;
  logic [32:0] skip_dec;
  logic [32:0] skip_pad;
  logic        emit;
  logic [2:0]  st;
  logic [31:0] size_e;
  logic        ok;

  assign fire     = in_valid_i && res_ready_i;
  assign in_pop_o = fire;
  assign b        = in_beat_i.data;
  assign ws_sh    = {b, word_q[31:8]};
  assign idx_inc  = idx_q + 5'd1;
  assign skip_dec = (skip_q != '0) ? skip_q - 33'd1 : skip_q;
  assign skip_pad = {1'b0, ws_sh} + {32'd0, ws_sh[0]};

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    word_d  = word_q;
    tag_d   = tag_q;
    skip_d  = skip_q;
    fmt_d   = fmt_q;
    emit    = 1'b0;
    st      = ST_OK;
    size_e  = '0;
    if (fire) begin
      unique case (phase_q)
        PH_HDR: begin
          word_d = ws_sh;
          idx_d  = idx_inc;
          if (idx_inc == TAG_LEN) tag_d = ws_sh;
          if (idx_inc >= HDR_LEN) begin
            idx_d = '0;
            if (tag_q != TAG_RIFF) begin
              emit = 1'b1;
              st   = ST_BAD_RIFF;
            end else if (ws_sh != TAG_WAVE) begin
              emit = 1'b1;
              st   = ST_BAD_WAVE;
            end else begin
              phase_d = PH_FHDR;
            end
          end
        end
        PH_FHDR, PH_DHDR: begin
          word_d = ws_sh;
          idx_d  = idx_inc;
          if (idx_inc == TAG_LEN) tag_d = ws_sh;
          if (idx_inc >= CHUNK_HDR_LEN) begin
            idx_d = '0;
            if (phase_q == PH_FHDR && tag_q == TAG_FMT) begin
              skip_d  = (ws_sh > 32'(FMT_BODY_LEN)) ?
                        {1'b0, ws_sh - 32'(FMT_BODY_LEN)} : '0;
              phase_d = PH_FBODY;
            end else if (phase_q == PH_DHDR && tag_q == TAG_DATA) begin
              emit   = 1'b1;
              st     = ST_OK;
              size_e = ws_sh;
            end else begin
              skip_d = skip_pad;
              if (skip_pad != '0) begin
                phase_d = (phase_q == PH_FHDR) ? PH_FSKIP : PH_DSKIP;
              end
            end
          end
        end
        PH_FBODY: begin
          fmt_d[idx_q[3:0]] = b;
          idx_d = idx_inc;
          if (idx_inc >= FMT_BODY_LEN) begin
            idx_d = '0;
            if ({fmt_q[1], fmt_q[0]} != FMT_PCM) begin
              emit = 1'b1;
              st   = ST_NOT_PCM;
            end else if ({b, fmt_q[14]} != SAMPLE_BITS) begin
              emit = 1'b1;
              st   = ST_NOT_16BIT;
            end else begin
              phase_d = (skip_q != '0) ? PH_DSKIP : PH_DHDR;
            end
          end
        end
        PH_FSKIP, PH_DSKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = (phase_q == PH_FSKIP) ? PH_FHDR : PH_DHDR;
          end
        end
        default: begin
        end
      endcase
      if (emit) phase_d = PH_DONE;
      if (in_beat_i.last) begin
        // status follows the phase reached after this beat
        if (!emit && phase_q != PH_DONE) begin
          emit = 1'b1;
          priority if (phase_d == PH_HDR) begin
            st = ST_SHORT_HDR;
          end else if (phase_d == PH_FHDR || phase_d == PH_FBODY ||
                       phase_d == PH_FSKIP) begin
            st = ST_NO_FMT;
          end else begin
            st = ST_NO_DATA;
          end
        end
        phase_d = PH_HDR;
        idx_d   = '0;
        word_d  = '0;
        tag_d   = '0;
        skip_d  = '0;
      end
    end
  end

  assign ok          = (st == ST_OK);
  assign res_valid_o = emit;

  always_comb begin
    res_o.status           = st;
    res_o.channel_count    = ok ? {fmt_q[3], fmt_q[2]} : '0;
    res_o.rate_hz          = ok ? {fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]} : '0;
    res_o.bytes_per_second = ok ? {fmt_q[11], fmt_q[10], fmt_q[9], fmt_q[8]} : '0;
    res_o.frame_align      = ok ? {fmt_q[13], fmt_q[12]} : '0;
    res_o.payload_size     = ok ? size_e : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      idx_q   <= '0;
      word_q  <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      word_q  <= word_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fmt_q <= fmt_d;
  end

endmodule

// ===== hdl/wav_riff_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser_top
// WAV header parser: byte queue in front, chunk walker behind, result queue.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  bytes in | push / full        | byte_in_i, stream_end_i
//  results  | empty / pop        | status_o, channel_count_o, rate_hz_o,
//           |                    | bytes_per_second_o, frame_align_o,
//           |                    | payload_size_o
//
//  One byte per cycle sustained while the result queue has room. Bytes pass
//  through the input queue before the walker takes them; a result (if any) is
//  registered into the result queue as the walker takes the byte behind it.
//  Reset empties both queues and returns the walker to the RIFF header.
//  A full result queue stalls the walker; the input queue then fills.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top #(
  parameter int InDepth  = 2,
  parameter int OutDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] rate_hz_o,
  output logic [31:0] bytes_per_second_o,
  output logic [15:0] frame_align_o,
  output logic [31:0] payload_size_o
);
  import wrp_pkg::*;

  beat_t   in_beat, q_beat;
  logic    q_empty, q_pop;
  result_t res, out_res;
  logic    res_valid, out_full;

  assign in_beat.data = byte_in_i;
  assign in_beat.last = stream_end_i;

  wrp_fifo #(
    .Depth(InDepth),
    .Width($bits(beat_t))
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_beat),
    .full_o (full),
    .pop_i  (q_pop),
    .data_o (q_beat),
    .empty_o(q_empty)
  );

  wrp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_beat_i  (q_beat),
    .in_pop_o   (q_pop),
    .res_ready_i(!out_full),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wrp_fifo #(
    .Depth(OutDepth),
    .Width($bits(result_t))
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign status_o           = out_res.status;
  assign channel_count_o    = out_res.channel_count;
  assign rate_hz_o          = out_res.rate_hz;
  assign bytes_per_second_o = out_res.bytes_per_second;
  assign frame_align_o      = out_res.frame_align;
  assign payload_size_o     = out_res.payload_size;

  a_no_res_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result produced while result queue full");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("walker took a beat from an empty queue");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (channel_count_o == '0 && rate_hz_o == '0 &&
      bytes_per_second_o == '0 && frame_align_o == '0 && payload_size_o == '0))
    else $error("error result carries nonzero fields");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream testbench for the WAV RIFF header parser. WAV streams are built
// byte by byte (well-formed headers with random contents, broken tags, bad
// formats, cut streams, padded and oversize chunks, noise) and pushed through
// the input queue. A cycle-free model of the chunk walker tracks every
// accepted beat and queues the result it should cause. A monitor compares
// each popped result field by field against the oldest queued one. Both
// sides idle at random, and one phase holds off the result side so that the
// input stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import wrp_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  byte_in_i;
  logic        stream_end_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [15:0] channel_count_o;
  logic [31:0] rate_hz_o;
  logic [31:0] bytes_per_second_o;
  logic [15:0] frame_align_o;
  logic [31:0] payload_size_o;

  wav_riff_header_parser_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .byte_in_i          (byte_in_i),
    .stream_end_i       (stream_end_i),
    .empty              (empty),
    .pop                (pop),
    .status_o           (status_o),
    .channel_count_o    (channel_count_o),
    .rate_hz_o          (rate_hz_o),
    .bytes_per_second_o (bytes_per_second_o),
    .frame_align_o      (frame_align_o),
    .payload_size_o     (payload_size_o)
  );

  // walker model state
  phase_e       wk_phase;
  logic [4:0]   wk_idx;
  logic [31:0]  wk_shift;
  logic [31:0]  wk_tag;
  logic [32:0]  wk_skip;
  logic [127:0] wk_body;
  logic         wk_done;

  result_t      parsed_q[$];
  logic [7:0]   wav_bytes[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_len = 0;
  int bytes_sent = 0;
  int streams_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int status_hits[8];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  task automatic clear_walker();
    wk_phase = PH_HDR;
    wk_idx   = '0;
    wk_shift = '0;
    wk_tag   = '0;
    wk_skip  = '0;
    wk_body  = '0;
    wk_done  = 1'b0;
  endtask

  task automatic post_result(input logic [2:0] st, input logic [31:0] size);
    result_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.channel_count    = wk_body[31:16];
      r.rate_hz          = wk_body[63:32];
      r.bytes_per_second = wk_body[95:64];
      r.frame_align      = wk_body[111:96];
      r.payload_size     = size;
    end
    parsed_q.push_back(r);
    wk_done  = 1'b1;
    wk_phase = PH_DONE;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic last);
    logic [31:0] size;
    logic [2:0]  st;
    if (!wk_done) begin
      case (wk_phase)
        PH_HDR: begin
          wk_shift = {b, wk_shift[31:8]};
          wk_idx++;
          if (wk_idx == TAG_LEN) wk_tag = wk_shift;
          if (wk_idx >= HDR_LEN) begin
            wk_idx = '0;
            if (wk_tag != TAG_RIFF) post_result(ST_BAD_RIFF, '0);
            else if (wk_shift != TAG_WAVE) post_result(ST_BAD_WAVE, '0);
            else wk_phase = PH_FHDR;
          end
        end
        PH_FHDR, PH_DHDR: begin
          wk_shift = {b, wk_shift[31:8]};
          wk_idx++;
          if (wk_idx == TAG_LEN) wk_tag = wk_shift;
          if (wk_idx >= CHUNK_HDR_LEN) begin
            size   = wk_shift;
            wk_idx = '0;
            if (wk_phase == PH_FHDR && wk_tag == TAG_FMT) begin
              wk_body  = '0;
              wk_skip  = (size > FMT_BODY_LEN) ? 33'(size - FMT_BODY_LEN) : '0;
              wk_phase = PH_FBODY;
            end else if (wk_phase == PH_DHDR && wk_tag == TAG_DATA) begin
              post_result(ST_OK, size);
            end else begin
              wk_skip = 33'(size) + 33'(size[0]);
              if (wk_skip != '0) wk_phase = (wk_phase == PH_FHDR) ? PH_FSKIP : PH_DSKIP;
            end
          end
        end
        PH_FBODY: begin
          wk_body[8*wk_idx +: 8] = b;
          wk_idx++;
          if (wk_idx >= FMT_BODY_LEN) begin
            wk_idx = '0;
            if (wk_body[15:0] != FMT_PCM) post_result(ST_NOT_PCM, '0);
            else if (wk_body[127:112] != SAMPLE_BITS) post_result(ST_NOT_16BIT, '0);
            else wk_phase = (wk_skip != '0) ? PH_DSKIP : PH_DHDR;
          end
        end
        PH_FSKIP, PH_DSKIP: begin
          if (wk_skip != '0) wk_skip--;
          if (wk_skip == '0) wk_phase = (wk_phase == PH_FSKIP) ? PH_FHDR : PH_DHDR;
        end
        default: ;
      endcase
    end
    if (last) begin
      if (!wk_done) begin
        case (wk_phase)
          PH_HDR:                     st = ST_SHORT_HDR;
          PH_FHDR, PH_FBODY, PH_FSKIP: st = ST_NO_FMT;
          default:                    st = ST_NO_DATA;
        endcase
        post_result(st, '0);
      end
      clear_walker();
    end
  endtask

  // ---------------------------------------------------------------- driving
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         = 1'b1;
    byte_in_i    = b;
    stream_end_i = last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    walk_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
    push = 1'b0;
  endtask

  // keep = 0 (or keep not below the stream length) sends the whole stream, else only its first keep bytes
  task automatic send_stream(input int keep);
    int n;
    n = (keep > 0 && keep < wav_bytes.size()) ? keep : wav_bytes.size();
    for (int i = 0; i < n; i++) send_beat(wav_bytes[i], i == n - 1);
    wav_bytes.delete();
    streams_sent++;
  endtask

  // ---------------------------------------------------------------- stream builders
  task automatic add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_fill(input int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_riff(input logic [31:0] riff, input logic [31:0] wave);
    add_le(riff, 4);
    add_le($urandom, 4);
    add_le(wave, 4);
  endtask

  task automatic add_junk(input logic [31:0] tag, input int size);
    add_le(tag, 4);
    add_le(size, 4);
    add_fill(size + size % 2);
  endtask

  task automatic add_fmt(input logic [31:0] fsize, input logic [15:0] code, chan,
                         input logic [31:0] rate, brate, input logic [15:0] align, bits);
    add_le(TAG_FMT, 4);
    add_le(fsize, 4);
    add_le(code, 2);
    add_le(chan, 2);
    add_le(rate, 4);
    add_le(brate, 4);
    add_le(align, 2);
    add_le(bits, 2);
    if (fsize > 16) add_fill(int'(fsize) - 16);
  endtask

  task automatic add_data_hdr(input logic [31:0] size);
    add_le(TAG_DATA, 4);
    add_le(size, 4);
  endtask

  task automatic build_pcm(input logic [15:0] chan, input logic [31:0] rate, brate,
                           input logic [15:0] align, input logic [31:0] size);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, chan, rate, brate, align, SAMPLE_BITS);
    add_data_hdr(size);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] flip_bit();
    return 32'h1 << $urandom_range(0, 31);
  endfunction

  // tags that must be skipped: the other phase's tag, near misses, random
  function automatic logic [31:0] junk_tag(input bit before_fmt);
    case ($urandom_range(0, 3))
      0:       return before_fmt ? TAG_DATA : TAG_FMT;
      1:       return (before_fmt ? TAG_FMT : TAG_DATA) ^ flip_bit();
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    build_pcm('0, '0, '0, '0, '0);
    send_stream(0);
    build_pcm('1, '1, '1, '1, '1);
    add_fill(3);
    send_stream(0);
    build_pcm(16'd2, 32'd44100, 32'd176400, 16'd4, 32'h0001_0000);
    add_fill(1);
    send_stream(0);
  endtask

  task automatic test_header_faults();
    add_riff(TAG_RIFF ^ 32'h0000_0080, TAG_WAVE);
    add_fmt(16, FMT_PCM, 1, 8000, 16000, 2, SAMPLE_BITS);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE ^ 32'h0100_0000);
    add_fill(4);
    send_stream(0);
    add_riff(~TAG_RIFF, ~TAG_WAVE);
    send_stream(0);
    add_fill(1);
    send_stream(0);
    add_riff(TAG_RIFF ^ 32'h1, TAG_WAVE);
    send_stream(4);
    add_riff(TAG_RIFF, TAG_WAVE);
    send_stream(11);
  endtask

  task automatic test_format_faults();
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, 16'd0, 2, 8000, 32000, 4, SAMPLE_BITS);
    add_data_hdr(8);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, 16'hFFFF, 2, 8000, 32000, 4, SAMPLE_BITS);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, 16'd3, 2, 8000, 32000, 4, 16'd24);
    add_data_hdr(8);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(18, FMT_PCM, 1, 8000, 8000, 1, 16'd8);
    add_data_hdr(8);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, 1, 8000, 8000, 1, 16'hFFFF);
    add_data_hdr(8);
    send_stream(0);
    // declared fmt size below the body length: body still read in full
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(0, FMT_PCM, 6, 48000, 576000, 12, SAMPLE_BITS);
    add_data_hdr(32'h00AB_CDEF);
    send_stream(0);
  endtask

  task automatic test_early_end();
    add_riff(TAG_RIFF, TAG_WAVE);
    add_junk(32'h5453_494C, 6);
    send_stream(18);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, 2, 8000, 32000, 4, SAMPLE_BITS);
    send_stream(27);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_le(32'h4B4E_554A, 4);
    add_le(32'hFFFF_FFFF, 4);
    add_fill(6);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(24, FMT_PCM, 2, 8000, 32000, 4, SAMPLE_BITS);
    add_data_hdr(4);
    send_stream(39);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, 2, 8000, 32000, 4, SAMPLE_BITS);
    add_le(32'h4B4E_554A, 4);
    add_le(32'hFFFF_FFFE, 4);
    add_fill(4);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, 2, 8000, 32000, 4, SAMPLE_BITS);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_fmt(16, FMT_PCM, 2, 8000, 32000, 4, SAMPLE_BITS);
    add_junk(32'h5453_494C, 3);
    send_stream(0);
    build_pcm(2, 8000, 32000, 4, 100);
    send_stream(wav_bytes.size() - 1);
  endtask

  task automatic test_chunk_skipping();
    add_riff(TAG_RIFF, TAG_WAVE);
    add_junk(TAG_DATA, 5);
    add_junk(TAG_FMT ^ 32'h0100_0000, 0);
    add_junk(32'h5453_494C, 1);
    add_fmt(17, FMT_PCM, 2, 22050, 88200, 4, SAMPLE_BITS);
    add_junk(TAG_FMT, 3);
    add_junk(TAG_DATA ^ 32'h2, 2);
    add_data_hdr(32'h0000_1234);
    add_fill(2);
    send_stream(0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_junk(TAG_DATA, 4);
    add_junk($urandom, 7);
    send_stream(0);
  endtask

  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    hold_len   = LONG_HOLD;
    repeat (24) begin
      add_fill(1);
      send_stream(0);
    end
    repeat (4) begin
      add_riff($urandom, TAG_WAVE);
      send_stream(0);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic gen_random_stream();
    int          kind;
    int          keep;
    logic [15:0] code;
    logic [15:0] bits;
    logic [31:0] fsize;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      add_fill($urandom_range(1, 24));
      send_stream(0);
      return;
    end
    code  = FMT_PCM;
    bits  = SAMPLE_BITS;
    if (kind < 14) code = rand_half();
    else if (kind < 20) bits = rand_half();
    add_riff((kind >= 20 && kind < 24) ? TAG_RIFF ^ flip_bit() : TAG_RIFF,
             (kind >= 24 && kind < 27) ? TAG_WAVE ^ flip_bit() : TAG_WAVE);
    repeat ($urandom_range(0, 2)) add_junk(junk_tag(1'b1), $urandom_range(0, 9));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: fsize = 16;
      6, 7:             fsize = $urandom_range(0, 15);
      default:          fsize = $urandom_range(17, 24);
    endcase
    if (kind < 43 || kind >= 46)
      add_fmt(fsize, code, rand_half(), rand_word(), rand_word(), rand_half(), bits);
    repeat ($urandom_range(0, 2)) add_junk(junk_tag(1'b0), $urandom_range(0, 9));
    if (kind < 27 || kind >= 31) begin
      add_data_hdr(rand_word());
      add_fill($urandom_range(0, 3));
    end
    keep = (kind >= 31 && kind < 43) ? $urandom_range(1, wav_bytes.size()) : 0;
    send_stream(keep);
  endtask

  task automatic test_random_streams();
    while (bytes_sent < ITEM_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      gen_random_stream();
    end
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_len > 0) begin
        pop = 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, status_o);
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("channel_count", want.channel_count, channel_count_o);
        check_field("rate_hz", want.rate_hz, rate_hz_o);
        check_field("bytes_per_second", want.bytes_per_second, bytes_per_second_o);
        check_field("frame_align", want.frame_align, frame_align_o);
        check_field("payload_size", want.payload_size, payload_size_o);
        status_hits[want.status]++;
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, parsed_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    byte_in_i    = '0;
    stream_end_i = 1'b0;
    clear_walker();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_header_faults();
    test_format_faults();
    test_early_end();
    test_chunk_skipping();
    test_back_pressure();
    test_random_streams();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d streams, checked %0d results", bytes_sent,
             streams_sent, results_seen);
    $display("Status mix ok/short/riff/wave/pcm/bits/nofmt/nodata: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
